>>> rtl/sector_chain_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef SECTOR_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define SECTOR_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH

// Check that cond implies expr in the same cycle.
`define SCAU_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that cond implies expr in the next cycle.
`define SCAU_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/scau_pkg.sv
`default_nettype none

package scau_pkg;

  // Sector codes and field widths
  localparam int SECTOR_BITS     = 16;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COUNT_W         = 13;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int OP_W            = 3;

  localparam logic [SECTOR_BITS-1:0] SECT_NONE  = '1;
  localparam logic [COUNT_W-1:0]     COUNT_MAX  = '1;
  localparam logic [SECTOR_BITS-1:0] BASE_RST   = SECTOR_BITS'(2);
  localparam logic [COUNT_W-1:0]     COUNT_RST  = COUNT_W'(4096);

  // Operation codes
  localparam logic [OP_W-1:0] OP_FORMAT   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT     = 3'd3;
  localparam logic [OP_W-1:0] OP_LINK     = 3'd4;
  localparam logic [OP_W-1:0] OP_MARK_END = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [SECTOR_BITS-1:0] sector;
    logic [SECTOR_BITS-1:0] chain_head;
  } req_t;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] result_sector;
    logic                   ok;
    logic [COUNT_W-1:0]     free_left;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FORMAT,
    ST_WALK,
    ST_TAIL
  } state_t;

endpackage

`default_nettype wire

>>> rtl/scau_ram.sv
`default_nettype none

module scau_ram #(
  parameter int WIDTH = scau_pkg::SECTOR_BITS,
  parameter int DEPTH = scau_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sector_chain_allocator_unit.sv
`default_nettype none

// Linked sector allocator. A request is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with done high, and
// the receiver has no way to hold it off. Alloc, free, next, mark_end and
// unused op codes do at most one table read and one table write each: the
// link table is a single-port-read RAM with registered read data. Format
// writes one table entry per cycle, N entries in all, N being data_count
// clamped to the table depth and to the sectors below the none code. Link
// follows the chain one entry per cycle (one RAM read each) and appends at
// its end; the walk stops without an append on a bad link or a cycle. The
// table content is undefined after reset until a format request has run;
// data_base and data_count may be rewritten only while idle.
module sector_chain_allocator_unit #(
  parameter int TABLE_DEPTH = scau_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire scau_pkg::req_t                 req,
  output logic                                done,
  output scau_pkg::rsp_t                      rsp,
  input  wire logic                           cfg_we,
  input  wire logic [scau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scau_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SB     = scau_pkg::SECTOR_BITS;
  localparam int CW     = scau_pkg::COUNT_W;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [SB:0] DEPTH_X = (SB + 1)'(TABLE_DEPTH);
  localparam logic [SB:0] CMAX_X  = (SB + 1)'(scau_pkg::COUNT_MAX);

  typedef logic [SB-1:0] sect_t;

  // Registers
  scau_pkg::state_t         state;
  scau_pkg::state_t         state_next;
  logic [scau_pkg::OP_W-1:0] op_q;
  sect_t                    sector_q;
  sect_t                    head_q;
  logic [ADDR_W-1:0]        cur_rel;
  logic [ADDR_W-1:0]        cur_rel_next;
  logic [CNT_W-1:0]         step;
  logic [CNT_W-1:0]         step_next;
  sect_t                    free_head;
  sect_t                    free_head_next;
  logic [CW-1:0]            free_total;
  logic [CW-1:0]            free_total_next;
  sect_t                    data_base;
  logic [CW-1:0]            data_count;

  // Table port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  sect_t             mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  sect_t             mem_rdata;

  // Control and result
  logic  accept;
  logic  finish;
  logic  walk;
  sect_t res_sect;
  logic  res_ok;

  // Decoded conditions
  logic [SB:0]      cap_x;
  logic [SB:0]      room_x;
  logic [SB:0]      eff_x;
  logic [CNT_W-1:0] eff_cnt;
  logic             fh_ok;
  logic             sec_ok;
  logic             head_ok;
  sect_t            nxt_abs;
  logic             nxt_ok;
  logic [CNT_W-1:0] step_inc;
  logic             walk_hit;
  logic             walk_stop;

  function automatic logic usable(sect_t abs, sect_t base, logic [SB:0] effx);
    sect_t diff;
    diff = abs - base;
    return (abs != scau_pkg::SECT_NONE) && (abs >= base) &&
           ((SB + 1)'(diff) < effx);
  endfunction

  function automatic logic [ADDR_W-1:0] rel_of(sect_t abs, sect_t base);
    sect_t diff;
    diff = abs - base;
    return diff[ADDR_W-1:0];
  endfunction

  function automatic sect_t to_abs(sect_t lk, sect_t base);
    return (lk == scau_pkg::SECT_NONE) ? scau_pkg::SECT_NONE : sect_t'(lk + base);
  endfunction

  scau_ram #(
    .WIDTH (SB),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != scau_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Effective sector count: clamp to table depth and to codes below none
  assign cap_x   = ((SB + 1)'(data_count) > DEPTH_X) ? DEPTH_X : (SB + 1)'(data_count);
  assign room_x  = (SB + 1)'(scau_pkg::SECT_NONE - data_base);
  assign eff_x   = (data_base == scau_pkg::SECT_NONE) ? '0 :
                   ((cap_x > room_x) ? room_x : cap_x);
  assign eff_cnt = eff_x[CNT_W-1:0];

  assign fh_ok     = usable(free_head, data_base, eff_x);
  assign sec_ok    = usable(sector_q, data_base, eff_x);
  assign head_ok   = usable(head_q, data_base, eff_x);
  assign nxt_abs   = to_abs(mem_rdata, data_base);
  assign nxt_ok    = usable(nxt_abs, data_base, eff_x);
  assign step_inc  = step + CNT_W'(1);
  assign walk_hit  = (mem_rdata == scau_pkg::SECT_NONE);
  assign walk_stop = !nxt_ok || (step_inc == eff_cnt);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      scau_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = scau_pkg::ST_EXEC;
        end
      end
      scau_pkg::ST_EXEC: begin
        case (op_q)
          scau_pkg::OP_FORMAT: state_next = scau_pkg::ST_FORMAT;
          scau_pkg::OP_LINK: begin
            if (!(head_ok && sec_ok) || (!walk_hit && walk_stop)) begin
              state_next = scau_pkg::ST_IDLE;
            end else if (walk_hit) begin
              state_next = scau_pkg::ST_TAIL;
            end else begin
              state_next = scau_pkg::ST_WALK;
            end
          end
          default: state_next = scau_pkg::ST_IDLE;
        endcase
      end
      scau_pkg::ST_FORMAT: begin
        if (step >= eff_cnt) begin
          state_next = scau_pkg::ST_IDLE;
        end
      end
      scau_pkg::ST_WALK: begin
        if (walk_hit) begin
          state_next = scau_pkg::ST_TAIL;
        end else if (walk_stop) begin
          state_next = scau_pkg::ST_IDLE;
        end
      end
      scau_pkg::ST_TAIL: state_next = scau_pkg::ST_IDLE;
      default:           state_next = scau_pkg::ST_IDLE;
    endcase
  end

  // Table access, counters and result
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = cur_rel;
    mem_wdata       = scau_pkg::SECT_NONE;
    mem_raddr       = rel_of(req.sector, data_base);
    cur_rel_next    = cur_rel;
    step_next       = step;
    free_head_next  = free_head;
    free_total_next = free_total;
    res_sect        = scau_pkg::SECT_NONE;
    res_ok          = 1'b0;
    finish          = 1'b0;
    walk            = 1'b0;
    case (state)
      scau_pkg::ST_IDLE: begin
        // Issue the first read as the request is taken
        case (req.op)
          scau_pkg::OP_ALLOC: mem_raddr = rel_of(free_head, data_base);
          scau_pkg::OP_LINK:  mem_raddr = rel_of(req.chain_head, data_base);
          default:            mem_raddr = rel_of(req.sector, data_base);
        endcase
        if (accept) begin
          cur_rel_next = rel_of(req.chain_head, data_base);
          step_next    = '0;
        end
      end
      scau_pkg::ST_EXEC: begin
        case (op_q)
          scau_pkg::OP_FORMAT: ;
          scau_pkg::OP_ALLOC: begin
            finish = 1'b1;
            if (fh_ok) begin
              // Pop the free head and terminate the popped entry
              res_sect       = free_head;
              res_ok         = 1'b1;
              free_head_next = nxt_abs;
              mem_we         = 1'b1;
              mem_waddr      = rel_of(free_head, data_base);
              if (free_total != '0) begin
                free_total_next = free_total - CW'(1);
              end
            end
          end
          scau_pkg::OP_FREE: begin
            finish = 1'b1;
            if (sec_ok) begin
              // Push onto the free head
              res_ok         = 1'b1;
              mem_we         = 1'b1;
              mem_waddr      = rel_of(sector_q, data_base);
              mem_wdata      = (free_head == scau_pkg::SECT_NONE) ? scau_pkg::SECT_NONE :
                               sect_t'(free_head - data_base);
              free_head_next = sector_q;
              if (free_total != scau_pkg::COUNT_MAX) begin
                free_total_next = free_total + CW'(1);
              end
            end
          end
          scau_pkg::OP_NEXT: begin
            finish = 1'b1;
            if (sec_ok) begin
              res_sect = nxt_abs;
              res_ok   = 1'b1;
            end
          end
          scau_pkg::OP_MARK_END: begin
            finish = 1'b1;
            if (sector_q == scau_pkg::SECT_NONE) begin
              res_ok = 1'b1;
            end else if (sec_ok) begin
              res_ok    = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = rel_of(sector_q, data_base);
            end
          end
          scau_pkg::OP_LINK: begin
            if (head_ok && sec_ok) begin
              walk = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      scau_pkg::ST_FORMAT: begin
        if (step < eff_cnt) begin
          // Chain each entry to the one after it, the last to none
          mem_we    = 1'b1;
          mem_waddr = step[ADDR_W-1:0];
          mem_wdata = (step_inc < eff_cnt) ? SB'(step_inc) : scau_pkg::SECT_NONE;
          step_next = step_inc;
        end else begin
          free_head_next  = (eff_cnt != '0) ? data_base : scau_pkg::SECT_NONE;
          free_total_next = (eff_x > CMAX_X) ? scau_pkg::COUNT_MAX : CW'(eff_x);
          res_ok          = 1'b1;
          finish          = 1'b1;
        end
      end
      scau_pkg::ST_WALK: walk = 1'b1;
      scau_pkg::ST_TAIL: begin
        // Terminate the appended sector
        mem_we    = 1'b1;
        mem_waddr = rel_of(sector_q, data_base);
        res_ok    = 1'b1;
        finish    = 1'b1;
      end
      default: finish = 1'b1;
    endcase

    // One chain step: append at the end, else follow the link
    if (walk) begin
      if (walk_hit) begin
        mem_we    = 1'b1;
        mem_waddr = cur_rel;
        mem_wdata = SB'(rel_of(sector_q, data_base));
      end else if (walk_stop) begin
        finish = 1'b1;
      end else begin
        cur_rel_next = rel_of(nxt_abs, data_base);
        step_next    = step_inc;
        mem_raddr    = rel_of(nxt_abs, data_base);
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scau_pkg::ST_IDLE;
      done       <= 1'b0;
      free_head  <= scau_pkg::SECT_NONE;
      free_total <= '0;
      data_base  <= scau_pkg::BASE_RST;
      data_count <= scau_pkg::COUNT_RST;
    end else begin
      state      <= state_next;
      done       <= finish;
      free_head  <= free_head_next;
      free_total <= free_total_next;
      if (cfg_we) begin
        case (cfg_index)
          scau_pkg::REG_DATA_BASE:  data_base  <= cfg_wdata[SB-1:0];
          scau_pkg::REG_DATA_COUNT: data_count <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request payload, walk position and result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.op;
      sector_q <= req.sector;
      head_q   <= req.chain_head;
    end
    cur_rel <= cur_rel_next;
    step    <= step_next;
    if (finish) begin
      rsp.result_sector <= res_sect;
      rsp.ok            <= res_ok;
      rsp.free_left     <= free_total_next;
    end
  end

`include "sector_chain_allocator_unit_assert.svh"

  `SCAU_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy), "result without a busy cycle")
  `SCAU_ASSERT_SAME(a_walk_bound, clk, rst, state == scau_pkg::ST_WALK, step < eff_cnt, "chain walk ran past the sector count")
  `SCAU_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == scau_pkg::ST_EXEC, "request not taken into execution")
  `SCAU_ASSERT_SAME(a_alloc_sector, clk, rst, done && rsp.ok && (op_q == scau_pkg::OP_ALLOC), rsp.result_sector != scau_pkg::SECT_NONE, "successful alloc returned none")

endmodule

`default_nettype wire

>>> tb/sv/tb_sector_chain_allocator_unit.sv
`default_nettype none

module tb_sector_chain_allocator_unit;
  import scau_pkg::*;

  localparam int DEPTH    = TABLE_DEPTH_DEF;
  localparam int LIMIT    = 4_000_000;
  localparam int HELD_MAX = 32;

  // Op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Tracks the link table, free list and settings; owes one reply per request
  class alloc_scoreboard;
    logic [SECTOR_BITS-1:0] link_tbl [DEPTH];
    bit                     written  [DEPTH];
    logic [SECTOR_BITS-1:0] free_head;
    int                     free_total;
    logic [SECTOR_BITS-1:0] base;
    logic [COUNT_W-1:0]     count;
    rsp_t                   owed[$];
    logic [SECTOR_BITS-1:0] held[$];
    int                     errors;

    function new();
      free_head  = SECT_NONE;
      free_total = 0;
      base       = BASE_RST;
      count      = COUNT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      if (idx == REG_DATA_BASE) base = v;
      else count = v[COUNT_W-1:0];
    endfunction

    // Sectors managed: data_count clamped to the table and the codes below none
    function int eff_count();
      int n;
      n = count;
      if (n > DEPTH) n = DEPTH;
      if (base == SECT_NONE) return 0;
      if (n > int'(SECT_NONE) - int'(base)) n = int'(SECT_NONE) - int'(base);
      return n;
    endfunction

    function bit usable(logic [SECTOR_BITS-1:0] s, output int rel);
      rel = 0;
      if (s == SECT_NONE || s < base) return 1'b0;
      if (int'(s) - int'(base) >= eff_count()) return 1'b0;
      rel = int'(s) - int'(base);
      return 1'b1;
    endfunction

    // End links stay the end marker; others are offset by the base
    function logic [SECTOR_BITS-1:0] to_abs(logic [SECTOR_BITS-1:0] lk);
      return (lk == SECT_NONE) ? SECT_NONE : base + lk;
    endfunction

    function void keep(logic [SECTOR_BITS-1:0] s);
      held.push_back(s);
      if (held.size() > HELD_MAX) void'(held.pop_front());
    endfunction

    // True when a request would read a table entry that was never written
    function bit reads_blank(req_t r);
      int rel;
      int n;
      logic [SECTOR_BITS-1:0] lk;
      rel = 0;
      case (r.op)
        OP_ALLOC: begin
          if (usable(free_head, rel)) return !written[rel];
        end
        OP_NEXT: begin
          if (usable(r.sector, rel)) return !written[rel];
        end
        OP_LINK: begin
          if (usable(r.chain_head, rel)) begin
            n = eff_count();
            for (int i = 0; i < n; i++) begin
              if (!written[rel]) return 1'b1;
              lk = link_tbl[rel];
              if (lk == SECT_NONE) return 1'b0;
              if (!usable(to_abs(lk), rel)) return 1'b0;
            end
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    // Apply one request to the table and work out the reply it gives
    function rsp_t op_outcome(req_t r);
      rsp_t o;
      int rel;
      int srel;
      int n;
      logic [SECTOR_BITS-1:0] lk;
      o.result_sector = SECT_NONE;
      o.ok = 1'b0;
      rel = 0;
      srel = 0;
      case (r.op)
        OP_FORMAT: begin
          n = eff_count();
          for (int i = 0; i < n; i++) begin
            link_tbl[i] = (i + 1 < n) ? SECTOR_BITS'(i + 1) : SECT_NONE;
            written[i] = 1'b1;
          end
          free_head = (n != 0) ? base : SECT_NONE;
          free_total = n;
          o.ok = 1'b1;
        end
        OP_ALLOC: begin
          if (usable(free_head, rel)) begin
            o.result_sector = free_head;
            free_head = to_abs(link_tbl[rel]);
            link_tbl[rel] = SECT_NONE;
            if (free_total > 0) free_total--;
            o.ok = 1'b1;
            keep(o.result_sector);
          end
        end
        OP_FREE: begin
          if (usable(r.sector, rel)) begin
            link_tbl[rel] = (free_head == SECT_NONE) ? SECT_NONE : free_head - base;
            written[rel] = 1'b1;
            free_head = r.sector;
            if (free_total < int'(COUNT_MAX)) free_total++;
            o.ok = 1'b1;
          end
        end
        OP_NEXT: begin
          if (usable(r.sector, rel)) begin
            o.result_sector = to_abs(link_tbl[rel]);
            o.ok = 1'b1;
          end
        end
        OP_LINK: begin
          if (usable(r.chain_head, rel) && usable(r.sector, srel)) begin
            // walk to the end; a chain longer than the managed sector count is a cycle
            n = eff_count();
            for (int i = 0; i < n; i++) begin
              lk = link_tbl[rel];
              if (lk == SECT_NONE) begin
                link_tbl[rel] = SECTOR_BITS'(srel);
                link_tbl[srel] = SECT_NONE;
                written[srel] = 1'b1;
                o.ok = 1'b1;
                keep(r.sector);
                break;
              end
              if (!usable(to_abs(lk), rel)) break;
            end
          end
        end
        OP_MARK_END: begin
          if (r.sector == SECT_NONE) begin
            o.ok = 1'b1;
          end else if (usable(r.sector, rel)) begin
            link_tbl[rel] = SECT_NONE;
            written[rel] = 1'b1;
            o.ok = 1'b1;
          end
        end
        default: ;
      endcase
      o.free_left = COUNT_W'(free_total);
      return o;
    endfunction

    function void note(req_t r);
      owed.push_back(op_outcome(r));
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        $error("result with no request waiting: result_sector %h ok %b free_left %0d",
               got.result_sector, got.ok, got.free_left);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.result_sector !== want.result_sector) begin
        $error("result_sector: expected %h, got %h", want.result_sector, got.result_sector);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok: expected %b, got %b", want.ok, got.ok);
        errors++;
      end
      if (got.free_left !== want.free_left) begin
        $error("free_left: expected %0d, got %0d", want.free_left, got.free_left);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  req_t                 req = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  rsp_t                 rsp;
  int unsigned          cycles = 0;

  alloc_scoreboard sb = new();

  sector_chain_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_sector_chain_allocator_unit NOT OK");
      $finish;
    end
  end

  // Check every reply in the cycle it is shown
  always @(posedge clk) begin
    if (!rst && done) sb.check(rsp);
  end

  function automatic req_t mk(logic [OP_W-1:0] op, logic [SECTOR_BITS-1:0] s,
                              logic [SECTOR_BITS-1:0] h);
    req_t r;
    r.op = op;
    r.sector = s;
    r.chain_head = h;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Favor usable sectors and sectors in play; keep edges and noise in the mix
  function automatic logic [SECTOR_BITS-1:0] pick_sector();
    int eff;
    int roll;
    eff = sb.eff_count();
    roll = $urandom_range(0, 99);
    if (roll < 60 && eff > 0)
      return SECTOR_BITS'(int'(sb.base) + int'($urandom_range(0, eff - 1)));
    if (roll < 72 && sb.held.size() > 0)
      return sb.held[$urandom_range(0, sb.held.size() - 1)];
    if (roll < 78) return sb.free_head;
    if (roll < 82) return SECT_NONE;
    if (roll < 86) return sb.base - 1'b1;
    if (roll < 90) return SECTOR_BITS'(int'(sb.base) + eff);
    return SECTOR_BITS'($urandom);
  endfunction

  // Draw a request that never reads a table entry left unwritten
  function automatic req_t make_request();
    req_t r;
    int roll;
    for (int tries = 0; tries < 20; tries++) begin
      roll = $urandom_range(0, 99);
      r.sector = pick_sector();
      r.chain_head = SECTOR_BITS'($urandom);
      if (roll < 3) r.op = OP_FORMAT;
      else if (roll < 28) r.op = OP_ALLOC;
      else if (roll < 48) r.op = OP_FREE;
      else if (roll < 68) r.op = OP_NEXT;
      else if (roll < 83) begin
        r.op = OP_LINK;
        r.chain_head = pick_sector();
      end else if (roll < 95) r.op = OP_MARK_END;
      else if (roll < 97) r.op = OP_SPARE_LO;
      else r.op = OP_SPARE_HI;
      if (!sb.reads_blank(r)) return r;
    end
    r.op = OP_FORMAT;
    return r;
  endfunction

  // Hold the request until the block takes it
  task automatic send(req_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note(r);
  endtask

  // Drop start and wait for every reply and for the block to go idle
  task automatic drain();
    start <= 1'b0;
    while (sb.owed.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] base, logic [CFG_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= REG_DATA_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_DATA_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_DATA_BASE, base);
    sb.write_reg(REG_DATA_COUNT, count);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] base, logic [CFG_W-1:0] count, int items);
    bit calm;
    req_t r;
    drain();
    set_config(base, count);
    calm = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 3) != 0)
      send(mk(OP_FORMAT, SECTOR_BITS'($urandom), SECTOR_BITS'($urandom)), 0);
    for (int k = 0; k < items; k++) begin
      // switch between gap-free stretches and random idling
      if (k % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      r = make_request();
      send(r, calm ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty free list, unused codes, bad sectors, self loop, chains
    send(mk(OP_ALLOC, 16'h1234, SECT_NONE), pick_gap());
    send(mk(OP_SPARE_LO, SECT_NONE, 16'h0000), pick_gap());
    send(mk(OP_SPARE_HI, 16'h0000, SECT_NONE), pick_gap());
    send(mk(OP_MARK_END, SECT_NONE, 16'hA5A5), pick_gap());
    send(mk(OP_FREE, SECT_NONE, 16'h5A5A), pick_gap());
    send(mk(OP_NEXT, 16'd0, 16'd0), pick_gap());
    send(mk(OP_NEXT, 16'd1, 16'hFFFE), pick_gap());
    send(mk(OP_FREE, 16'd4098, 16'd2), pick_gap());
    send(mk(OP_FREE, 16'd4097, 16'd2), pick_gap());
    // free the same sector twice: it now links to itself
    send(mk(OP_FREE, 16'd4097, 16'd2), pick_gap());
    send(mk(OP_LINK, 16'd2, 16'd4097), pick_gap());
    send(mk(OP_FORMAT, 16'hFFFF, 16'hFFFF), pick_gap());
    send(mk(OP_ALLOC, 16'd0, 16'd0), pick_gap());
    send(mk(OP_ALLOC, 16'd0, 16'd0), pick_gap());
    send(mk(OP_NEXT, 16'd2, 16'd0), pick_gap());
    send(mk(OP_LINK, 16'd3, 16'd2), pick_gap());
    send(mk(OP_NEXT, 16'd2, 16'd0), pick_gap());
    send(mk(OP_LINK, 16'd3, SECT_NONE), pick_gap());
    send(mk(OP_LINK, SECT_NONE, 16'd2), pick_gap());
    send(mk(OP_MARK_END, 16'd2, 16'd0), pick_gap());
    send(mk(OP_FREE, 16'd3, 16'd0), pick_gap());
    send(mk(OP_LINK, 16'd4098, 16'd2), pick_gap());
    send(mk(OP_NEXT, SECT_NONE, 16'd0), pick_gap());
    send(mk(OP_LINK, 16'd2, 16'd4097), pick_gap());

    // Random requests over a range of settings, the extremes among them
    run_phase(16'd0, 16'd0, 60);
    run_phase(16'd65534, 16'd4096, 100);
    run_phase(16'd100, 16'd1, 120);
    run_phase(16'd37, 16'd8, 250);
    run_phase(16'd65500, 16'd4096, 200);
    run_phase(16'd2, 16'd4096, 80);
    run_phase(16'd4000, 16'd24, 250);
    run_phase(16'd9, 16'd3, 200);
    run_phase(CFG_W'($urandom_range(0, 65534)), CFG_W'($urandom_range(1, 48)), 150);
    run_phase(16'd1200, 16'd16, 250);
    run_phase(16'd2, 16'd64, 120);

    // Push a run of frees onto a full free list, then pop a few
    drain();
    set_config(16'd0, 16'd4096);
    send(mk(OP_FORMAT, 16'd0, 16'd0), 0);
    repeat (40)
      send(mk(OP_FREE, SECTOR_BITS'($urandom_range(0, DEPTH - 1)), SECTOR_BITS'($urandom)),
           ($urandom_range(0, 9) == 0) ? pick_gap() : 0);
    repeat (3) send(mk(OP_ALLOC, SECTOR_BITS'($urandom), SECTOR_BITS'($urandom)), pick_gap());

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_sector_chain_allocator_unit OK");
    end else begin
      $display("tb_sector_chain_allocator_unit NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/scau_pkg.sv
rtl/scau_ram.sv
rtl/sector_chain_allocator_unit.sv
tb/sv/tb_sector_chain_allocator_unit.sv
